@@ rtl/core/color_key_span_extractor_core_assert.svh @@
// Assertion macros shared by the color key span extractor RTL.
`ifndef COLOR_KEY_SPAN_EXTRACTOR_CORE_ASSERT_SVH
`define COLOR_KEY_SPAN_EXTRACTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define CKE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cke assertion failed");
// A condition in one cycle implies a consequence in the next.
`define CKE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cke assertion failed");
`else
`define CKE_ASSERT(label, prop)
`define CKE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/cke_pkg.sv @@
// Shared types and constants of the color key span extractor.
`timescale 1ns / 1ps

package cke_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int PALETTE_DEPTH = 256;
  localparam int CNT_W         = $clog2(MAX_DIM);
  localparam int DIM_W         = CNT_W + 1;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PIX_W         = 32;
  localparam int KEY_W         = 24;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [1:0] {
    FMT_PAL8  = 2'd0,
    FMT_RGB16 = 2'd1,
    FMT_RGB24 = 2'd2,
    FMT_RGB32 = 2'd3
  } pixel_format_e;

  typedef enum logic {
    OP_PIXEL     = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_KEY_COLOR    = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    pixel_format_e     fmt;
    logic [KEY_W-1:0]  key;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] left;
    logic [DIM_W-1:0] right;
  } span_t;

endpackage

@@ rtl/core/cke_if.sv @@
// Valid/ready channel interfaces for pixel input and span output.
`timescale 1ns / 1ps

interface cke_pix_if;
  import cke_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [PIX_W-1:0]      pixel_value;
  logic [PAL_AW-1:0]     palette_index;
  logic [PIX_W-1:0]      palette_entry;

  modport source (output valid, op, pixel_value, palette_index, palette_entry, input ready);
  modport sink   (input valid, op, pixel_value, palette_index, palette_entry, output ready);
endinterface

interface cke_span_if;
  import cke_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] span_row;
  logic [CNT_W-1:0] span_left;
  logic [DIM_W-1:0] span_right;

  modport source (output valid, span_row, span_left, span_right, input ready);
  modport sink   (input valid, span_row, span_left, span_right, output ready);
endinterface

@@ rtl/core/color_key_span_extractor_core.sv @@
// Color key span extractor: a raster pixel stream in, opaque spans out, one
// pixel per clock. A pixel transfer is registered together with its palette
// read, then tested against the key and the run state when it leaves the
// input stage, and a span it closes is registered in the output register.
// The input keeps taking one transfer every cycle as long as the output
// register is empty or being drained; only a stalled output with a pending
// span holds it off. A palette write takes one transfer, produces no span
// and leaves the row and column counters alone; a palette entry must be
// written before a pixel in 8-bit palette format refers to it.
// Configuration writes are meant for an idle block.
`timescale 1ns / 1ps

`include "color_key_span_extractor_core_assert.svh"

module color_key_span_extractor_core
  import cke_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  cke_pix_if.sink              pix_i,
  cke_span_if.source           span_o
);

  cfg_t cfg_q;

  logic             pix_fire, is_write, is_pixel;
  logic             a_valid_q, a_valid_d;
  logic [PIX_W-1:0] a_pixel_q;
  logic             a_fire;
  logic [PIX_W-1:0] pal_data;
  logic             emit;
  span_t            span;
  logic             out_valid_q;
  span_t            out_span_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= FMT_RGB32;
      cfg_q.key    <= KEY_W'(24'hFF00FF);
      cfg_q.width  <= DIM_W'(640);
      cfg_q.height <= DIM_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PIXEL_FORMAT: cfg_q.fmt    <= pixel_format_e'(cfg_data_i[1:0]);
        REG_KEY_COLOR:    cfg_q.key    <= cfg_data_i;
        REG_IMAGE_WIDTH:  cfg_q.width  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.height <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_fire      = a_valid_q && (!out_valid_q || span_o.ready);
  assign pix_i.ready = !a_valid_q || a_fire;
  assign pix_fire    = pix_i.valid && pix_i.ready;
  assign is_write    = pix_i.op == OP_PAL_WRITE;
  assign is_pixel    = !is_write;

  cke_palette_ram u_palette (
    .clk_i   (clk_i),
    .we_i    (pix_fire && is_write),
    .waddr_i (pix_i.palette_index),
    .wdata_i (pix_i.palette_entry),
    .re_i    (pix_fire && is_pixel),
    .raddr_i (pix_i.pixel_value[PAL_AW-1:0]),
    .rdata_o (pal_data)
  );

  // Only pixel transfers enter the input stage.
  always_comb begin
    a_valid_d = a_valid_q;
    if (pix_fire && is_pixel) begin
      a_valid_d = 1'b1;
    end else if (a_fire) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire && is_pixel) begin
      a_pixel_q <= pix_i.pixel_value;
    end
  end

  cke_span_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .step_i     (a_fire),
    .pixel_i    (a_pixel_q),
    .pal_data_i (pal_data),
    .emit_o     (emit),
    .span_o     (span)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_fire) begin
      out_valid_q <= emit;
    end else if (span_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && emit) begin
      out_span_q <= span;
    end
  end

  assign span_o.valid      = out_valid_q;
  assign span_o.span_row   = out_span_q.row;
  assign span_o.span_left  = out_span_q.left;
  assign span_o.span_right = out_span_q.right;

  // A row shrunk below an open run can give a span whose end lies at or
  // before its start, so only a nonzero end column is guaranteed.
  `CKE_ASSERT_NEXT(a_emit_lands, a_fire && emit, out_valid_q)
  `CKE_ASSERT_NEXT(pal_write_skips_stage, pix_fire && is_write, !a_valid_q)
  `CKE_ASSERT(span_right_nonzero, !out_valid_q || (out_span_q.right != '0))

endmodule

@@ rtl/core/cke_palette_ram.sv @@
// Palette memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module cke_palette_ram
  import cke_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [PAL_AW-1:0] waddr_i,
  input  logic [PIX_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [PAL_AW-1:0] raddr_i,
  output logic [PIX_W-1:0]  rdata_o
);

  logic [PIX_W-1:0] mem_q [PALETTE_DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/cke_span_track.sv @@
// Opacity test and run tracking: column, row and open-run state.
`timescale 1ns / 1ps

module cke_span_track
  import cke_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             step_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [PIX_W-1:0] pal_data_i,
  output logic             emit_o,
  output span_t            span_o
);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic             run_open_q, run_open_d;
  logic [CNT_W-1:0] start_q, start_d;

  logic [DIM_W-1:0] width_c, height_c;
  logic [KEY_W-1:0] key_rgb;
  logic [15:0]      key16;
  logic             opaque;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             last;
  logic             close_key, open_now, run_after;
  logic [CNT_W-1:0] start_eff;

  // Dimensions outside 1..MAX_DIM are clamped into range.
  always_comb begin
    width_c = cfg_i.width;
    if (cfg_i.width == '0) begin
      width_c = DIM_W'(1);
    end else if (cfg_i.width > DIM_W'(MAX_DIM)) begin
      width_c = DIM_W'(MAX_DIM);
    end
    height_c = cfg_i.height;
    if (cfg_i.height == '0) begin
      height_c = DIM_W'(1);
    end else if (cfg_i.height > DIM_W'(MAX_DIM)) begin
      height_c = DIM_W'(MAX_DIM);
    end
  end

  // The key register holds BGR with red in the low byte; compare as RGB.
  assign key_rgb = {cfg_i.key[7:0], cfg_i.key[15:8], cfg_i.key[23:16]};
  assign key16   = {key_rgb[23:19], key_rgb[15:10], key_rgb[7:3]};

  always_comb begin
    unique case (cfg_i.fmt)
      FMT_PAL8:  opaque = pal_data_i != {8'h00, key_rgb};
      FMT_RGB16: opaque = pixel_i[15:0] != key16;
      FMT_RGB24: opaque = pixel_i[23:0] != key_rgb;
      FMT_RGB32: opaque = pixel_i != {8'h00, key_rgb};
      default:   opaque = 1'b1;
    endcase
  end

  assign col_inc = {1'b0, col_q} + DIM_W'(1);
  assign row_inc = {1'b0, row_q} + DIM_W'(1);
  // Greater-or-equal so that a counter past a newly shrunk size still wraps.
  assign last    = col_inc >= width_c;

  assign close_key = run_open_q && !opaque;
  assign open_now  = !run_open_q && opaque;
  assign run_after = (run_open_q && opaque) || open_now;
  assign start_eff = open_now ? col_q : start_q;

  assign emit_o = close_key || (last && run_after);

  always_comb begin
    span_o.row = row_q;
    if (close_key) begin
      span_o.left  = start_q;
      span_o.right = {1'b0, col_q};
    end else begin
      span_o.left  = start_eff;
      span_o.right = width_c;
    end
  end

  always_comb begin
    run_open_d = run_after && !last;
    start_d    = start_eff;
    if (last) begin
      col_d = '0;
      row_d = (row_inc >= height_c) ? '0 : row_inc[CNT_W-1:0];
    end else begin
      col_d = col_inc[CNT_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      run_open_q <= 1'b0;
      start_q    <= '0;
    end else if (step_i) begin
      col_q      <= col_d;
      row_q      <= row_d;
      run_open_q <= run_open_d;
      start_q    <= start_d;
    end
  end

endmodule
